// File: sv/cpdu_pkg.sv
// ---------------------------------------------------------------------------
// cpdu_pkg: shared types and constants of the peel degree update block
// Sizes of the adjacency stores, item field widths, mode codes and the
// request structs that pass between the sequencer and the memories.
// ---------------------------------------------------------------------------
package cpdu_pkg;

  localparam int unsigned MAX_VERTICES       = 1024;
  localparam int unsigned MAX_NEIGHBOR_SLOTS = 4096;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned VAL_W  = 13;
  localparam int unsigned DEG_W  = 12;
  localparam int unsigned CNT_W  = 13;

  localparam int unsigned RS_DEPTH = MAX_VERTICES + 1;
  localparam int unsigned VTX_AW   = $clog2(MAX_VERTICES);
  localparam int unsigned RS_AW    = $clog2(RS_DEPTH);
  localparam int unsigned NB_AW    = $clog2(MAX_NEIGHBOR_SLOTS);

  localparam logic [DEG_W-1:0] DEG_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_ROW_START = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NEIGHBOR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEGREE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd4;

  typedef struct packed {
    logic             we;
    logic [RS_AW-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [RS_AW-1:0] raddr;
  } rs_req_t;

  typedef struct packed {
    logic             we;
    logic [NB_AW-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [NB_AW-1:0] raddr;
  } nb_req_t;

  typedef struct packed {
    logic              we;
    logic [VTX_AW-1:0] waddr;
    logic [DEG_W-1:0]  wdata;
    logic [VTX_AW-1:0] raddr;
  } dg_req_t;

  typedef struct packed {
    logic              we;
    logic [VTX_AW-1:0] waddr;
    logic              wdata;
    logic [VTX_AW-1:0] raddr;
  } fl_req_t;

  typedef struct packed {
    logic [DEG_W-1:0] degree;
    logic             is_deleted;
    logic [CNT_W-1:0] neighbors_updated;
    logic             bad_address;
  } result_t;

endpackage

// File: sv/core_peel_degree_update.sv
// ---------------------------------------------------------------------------
// core_peel_degree_update: degree bookkeeping for k-core peeling
// Holds a CSR adjacency in four memories and updates neighbour degrees
// when a vertex is peeled off the graph.
// ---------------------------------------------------------------------------
// Steps: a load, an out-of-range item or a spare mode goes straight to the output
// state; a degree write or a query passes the read state, a repeated delete the delete
// check, and a fresh delete also reads the range end and walks each neighbour slot.
// Throughput: one item at a time, taken the cycle after the previous result is pushed.
// Reset: asynchronous and active low. The deleted flags are then cleared by
// a pass over all 1024 vertices, during which no item is accepted.
// ---------------------------------------------------------------------------
module core_peel_degree_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cpdu_pkg::MODE_W-1:0]   in_mode_i,
  input  logic [cpdu_pkg::ADDR_W-1:0]   in_address_i,
  input  logic [cpdu_pkg::VAL_W-1:0]    in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cpdu_pkg::DEG_W-1:0]    out_degree_o,
  output logic                          out_is_deleted_o,
  output logic [cpdu_pkg::CNT_W-1:0]    out_neighbors_updated_o,
  output logic                          out_bad_address_o
);
  import cpdu_pkg::*;

  // Each memory has one write and one registered read port. The sequencer
  // issues reads for the accepted item straight away, so the data for a
  // delete or a query is ready in the first cycle after acceptance.
  rs_req_t          rs_req;
  nb_req_t          nb_req;
  dg_req_t          dg_req;
  fl_req_t          fl_req;
  logic [VAL_W-1:0] rs_rdata;
  logic [VAL_W-1:0] nb_rdata;
  logic [DEG_W-1:0] dg_rdata;
  logic             fl_rdata;
  logic             out_free;
  logic             push;
  result_t          res;
  logic             in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // The sequencer walks one neighbour slot at a time: read the slot, then
  // read the neighbour's degree and flag, then write the decremented degree
  // back. Only one access is ever in flight, so a neighbour that appears
  // twice in a range always sees its own earlier decrement.
  cpdu_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_mode_i    (in_mode_i),
    .in_address_i (in_address_i),
    .in_value_i   (in_value_i),
    .in_stall_o   (in_stall_o),
    .rs_req_o     (rs_req),
    .rs_rdata_i   (rs_rdata),
    .nb_req_o     (nb_req),
    .nb_rdata_i   (nb_rdata),
    .dg_req_o     (dg_req),
    .dg_rdata_i   (dg_rdata),
    .fl_req_o     (fl_req),
    .fl_rdata_i   (fl_rdata),
    .out_free_i   (out_free),
    .push_o       (push),
    .res_o        (res)
  );

  // Row starts: one entry more than there are vertices, so that the end of
  // the last vertex's range can be held.
  cpdu_ram #(.WIDTH(VAL_W), .DEPTH(RS_DEPTH)) u_row_start (
    .clk_i   (clk_i),
    .we_i    (rs_req.we),
    .waddr_i (rs_req.waddr),
    .wdata_i (rs_req.wdata),
    .raddr_i (rs_req.raddr),
    .rdata_o (rs_rdata)
  );

  // Neighbour entries are kept at full item width so that an entry beyond
  // the vertex range can still be recognised and skipped.
  cpdu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NEIGHBOR_SLOTS)) u_neighbor_list (
    .clk_i   (clk_i),
    .we_i    (nb_req.we),
    .waddr_i (nb_req.waddr),
    .wdata_i (nb_req.wdata),
    .raddr_i (nb_req.raddr),
    .rdata_o (nb_rdata)
  );

  cpdu_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_degree (
    .clk_i   (clk_i),
    .we_i    (dg_req.we),
    .waddr_i (dg_req.waddr),
    .wdata_i (dg_req.wdata),
    .raddr_i (dg_req.raddr),
    .rdata_o (dg_rdata)
  );

  cpdu_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_deleted (
    .clk_i   (clk_i),
    .we_i    (fl_req.we),
    .waddr_i (fl_req.waddr),
    .wdata_i (fl_req.wdata),
    .raddr_i (fl_req.raddr),
    .rdata_o (fl_rdata)
  );

  // The output register lets a finished result wait for the downstream side
  // while the sequencer returns to idle.
  cpdu_out_reg u_out_reg (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .push_i                  (push),
    .res_i                   (res),
    .free_o                  (out_free),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_degree_o            (out_degree_o),
    .out_is_deleted_o        (out_is_deleted_o),
    .out_neighbors_updated_o (out_neighbors_updated_o),
    .out_bad_address_o       (out_bad_address_o)
  );

  // Marking a vertex deleted always zeroes its degree in the same cycle.
  a_flag_zeroes_degree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fl_req.we && fl_req.wdata) |->
      (dg_req.we && (dg_req.wdata == '0) && (dg_req.waddr == fl_req.waddr)))
    else $error("deleted flag set without zeroing the degree");

  // An item is never accepted in the cycle its predecessor's result is pushed.
  a_accept_push_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !push)
    else $error("item accepted while a result is being pushed");

  // A result appears on the output only after the sequencer has pushed it.
  a_valid_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(push))
    else $error("output valid without a pushed result");

endmodule

// File: sv/cpdu_ram.sv
// ---------------------------------------------------------------------------
// cpdu_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
module cpdu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/cpdu_out_reg.sv
// ---------------------------------------------------------------------------
// cpdu_out_reg: result output register
// Holds one finished result until the downstream side takes it.
// ---------------------------------------------------------------------------
module cpdu_out_reg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  cpdu_pkg::result_t                     res_i,
  output logic                                  free_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [cpdu_pkg::DEG_W-1:0]            out_degree_o,
  output logic                                  out_is_deleted_o,
  output logic [cpdu_pkg::CNT_W-1:0]            out_neighbors_updated_o,
  output logic                                  out_bad_address_o
);
  import cpdu_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // The register may be reloaded when it is empty or being taken this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o             = valid_q;
  assign out_degree_o            = res_q.degree;
  assign out_is_deleted_o        = res_q.is_deleted;
  assign out_neighbors_updated_o = res_q.neighbors_updated;
  assign out_bad_address_o       = res_q.bad_address;

endmodule

// File: sv/cpdu_seq.sv
// ---------------------------------------------------------------------------
// cpdu_seq: item sequencer
// Decodes items, drives the four memories and walks a deleted vertex's
// neighbour range one slot at a time with read, modify and write-back.
// ---------------------------------------------------------------------------
module cpdu_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [cpdu_pkg::MODE_W-1:0]   in_mode_i,
  input  logic [cpdu_pkg::ADDR_W-1:0]   in_address_i,
  input  logic [cpdu_pkg::VAL_W-1:0]    in_value_i,
  output logic                          in_stall_o,
  output cpdu_pkg::rs_req_t             rs_req_o,
  input  logic [cpdu_pkg::VAL_W-1:0]    rs_rdata_i,
  output cpdu_pkg::nb_req_t             nb_req_o,
  input  logic [cpdu_pkg::VAL_W-1:0]    nb_rdata_i,
  output cpdu_pkg::dg_req_t             dg_req_o,
  input  logic [cpdu_pkg::DEG_W-1:0]    dg_rdata_i,
  output cpdu_pkg::fl_req_t             fl_req_o,
  input  logic                          fl_rdata_i,
  input  logic                          out_free_i,
  output logic                          push_o,
  output cpdu_pkg::result_t             res_o
);
  import cpdu_pkg::*;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_READ    = 4'd2;
  localparam logic [3:0] ST_DEL_CHK = 4'd3;
  localparam logic [3:0] ST_DEL_HI  = 4'd4;
  localparam logic [3:0] ST_SLOT    = 4'd5;
  localparam logic [3:0] ST_NBR     = 4'd6;
  localparam logic [3:0] ST_UPD     = 4'd7;
  localparam logic [3:0] ST_OUT     = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [VTX_AW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [VTX_AW-1:0] vtx_q, vtx_d;
  logic [DEG_W-1:0]  deg_q, deg_d;
  logic [VAL_W-1:0]  slot_q, slot_d;
  logic [VAL_W-1:0]  hi_q, hi_d;
  logic [VAL_W-1:0]  nbr_q, nbr_d;
  result_t           res_q, res_d;

  logic             accept;
  logic             addr_ok;
  logic [DEG_W-1:0] deg_sat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (in_mode_i)
      MODE_ROW_START: addr_ok = 32'(in_address_i) < 32'(RS_DEPTH);
      MODE_NEIGHBOR:  addr_ok = 32'(in_address_i) < 32'(MAX_NEIGHBOR_SLOTS);
      MODE_DEGREE,
      MODE_DELETE,
      MODE_QUERY:     addr_ok = 32'(in_address_i) < 32'(MAX_VERTICES);
      default:        addr_ok = 1'b1;
    endcase
  end

  assign deg_sat = (32'(in_value_i) > 32'(DEG_MAX)) ? DEG_MAX : DEG_W'(in_value_i);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    vtx_d   = vtx_q;
    deg_d   = deg_q;
    slot_d  = slot_q;
    hi_d    = hi_q;
    nbr_d   = nbr_q;
    res_d   = res_q;
    push_o  = 1'b0;

    rs_req_o       = '0;
    rs_req_o.raddr = RS_AW'(in_address_i);
    nb_req_o       = '0;
    nb_req_o.raddr = NB_AW'(slot_q);
    dg_req_o       = '0;
    dg_req_o.raddr = VTX_AW'(in_address_i);
    fl_req_o       = '0;
    fl_req_o.raddr = VTX_AW'(in_address_i);

    case (state_q)
      ST_CLEAR: begin
        fl_req_o.we    = 1'b1;
        fl_req_o.waddr = clr_q;
        fl_req_o.wdata = 1'b0;
        clr_d          = clr_q + 1'b1;
        if (32'(clr_q) == 32'(MAX_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_d = in_mode_i;
          vtx_d  = VTX_AW'(in_address_i);
          deg_d  = deg_sat;
          res_d  = '0;
          res_d.bad_address = !addr_ok;
          state_d = ST_OUT;
          if (addr_ok) begin
            case (in_mode_i)
              MODE_ROW_START: begin
                rs_req_o.we    = 1'b1;
                rs_req_o.waddr = RS_AW'(in_address_i);
                rs_req_o.wdata = in_value_i;
              end
              MODE_NEIGHBOR: begin
                nb_req_o.we    = 1'b1;
                nb_req_o.waddr = NB_AW'(in_address_i);
                nb_req_o.wdata = in_value_i;
              end
              MODE_DEGREE: begin
                dg_req_o.we    = 1'b1;
                dg_req_o.waddr = VTX_AW'(in_address_i);
                dg_req_o.wdata = deg_sat;
                state_d        = ST_READ;
              end
              MODE_QUERY:  state_d = ST_READ;
              MODE_DELETE: state_d = ST_DEL_CHK;
              default:     state_d = ST_OUT;
            endcase
          end
        end
      end
      ST_READ: begin
        res_d.degree     = (mode_q == MODE_DEGREE) ? deg_q : dg_rdata_i;
        res_d.is_deleted = fl_rdata_i;
        state_d          = ST_OUT;
      end
      ST_DEL_CHK: begin
        if (fl_rdata_i) begin
          // Already deleted: report the current degree and change nothing.
          res_d.degree     = dg_rdata_i;
          res_d.is_deleted = 1'b1;
          state_d          = ST_OUT;
        end else begin
          dg_req_o.we    = 1'b1;
          dg_req_o.waddr = vtx_q;
          dg_req_o.wdata = '0;
          fl_req_o.we    = 1'b1;
          fl_req_o.waddr = vtx_q;
          fl_req_o.wdata = 1'b1;
          rs_req_o.raddr = RS_AW'(32'(vtx_q) + 32'd1);
          slot_d         = rs_rdata_i;
          cnt_d          = '0;
          state_d        = ST_DEL_HI;
        end
      end
      ST_DEL_HI: begin
        hi_d = (32'(rs_rdata_i) > 32'(MAX_NEIGHBOR_SLOTS)) ?
               VAL_W'(MAX_NEIGHBOR_SLOTS) : rs_rdata_i;
        state_d = ST_SLOT;
      end
      ST_SLOT: begin
        if (slot_q < hi_q) begin
          state_d = ST_NBR;
        end else begin
          res_d.degree            = '0;
          res_d.is_deleted        = 1'b1;
          res_d.neighbors_updated = cnt_q;
          state_d                 = ST_OUT;
        end
      end
      ST_NBR: begin
        nbr_d = nb_rdata_i;
        if ((32'(nb_rdata_i) == 32'(vtx_q)) ||
            (32'(nb_rdata_i) >= 32'(MAX_VERTICES))) begin
          slot_d  = slot_q + 1'b1;
          state_d = ST_SLOT;
        end else begin
          dg_req_o.raddr = VTX_AW'(nb_rdata_i);
          fl_req_o.raddr = VTX_AW'(nb_rdata_i);
          state_d        = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!fl_rdata_i && (dg_rdata_i != '0)) begin
          dg_req_o.we    = 1'b1;
          dg_req_o.waddr = VTX_AW'(nbr_q);
          dg_req_o.wdata = dg_rdata_i - 1'b1;
          if (cnt_q != CNT_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        slot_d  = slot_q + 1'b1;
        state_d = ST_SLOT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    vtx_q  <= vtx_d;
    deg_q  <= deg_d;
    slot_q <= slot_d;
    hi_q   <= hi_d;
    nbr_q  <= nbr_d;
    res_q  <= res_d;
  end

endmodule

// File: verif/core_peel_degree_update_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// core_peel_degree_update_test: self-checking bench for the peel degree update
// Builds small CSR fragments, peels vertices out of them and queries degrees,
// mixed with out-of-range and spare-mode noise. A tracker class mirrors the
// four stores and predicts the single result that each item produces.
// ---------------------------------------------------------------------------
module core_peel_degree_update_test;
  import cpdu_pkg::*;

  // Spare mode codes that the block must answer with an all-zero result.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned DRAIN_CYCLES = 64;
  // Longest neighbour range that a peel is allowed to walk, to keep deletes short.
  localparam int unsigned WALK_MAX     = 64;
  localparam int unsigned FIELD_MAX    = (1 << VAL_W) - 1;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;

  // -------------------------------------------------------------------------
  // Degree tracker: a copy of the adjacency stores plus the results still owed.
  // The *_known flags record which entries have been written, so that the
  // stimulus never makes the block read an entry that holds no defined value.
  // -------------------------------------------------------------------------
  class degree_book;
    logic [VAL_W-1:0] row_first [RS_DEPTH];
    bit               row_known [RS_DEPTH];
    logic [VAL_W-1:0] adj_vertex [MAX_NEIGHBOR_SLOTS];
    bit               adj_known  [MAX_NEIGHBOR_SLOTS];
    logic [DEG_W-1:0] vtx_degree [MAX_VERTICES];
    bit               deg_known  [MAX_VERTICES];
    bit               vtx_gone   [MAX_VERTICES];
    result_t          owed_results [$];
    int unsigned      items_noted;
    int unsigned      fault_count;

    // Marks v deleted, zeroes it and decrements its live neighbours.
    function logic [CNT_W-1:0] strip_vertex(int v);
      int lo;
      int hi;
      int s;
      int u;
      logic [CNT_W-1:0] cut;
      lo = row_first[v];
      hi = row_first[v+1];
      cut = '0;
      vtx_degree[v] = '0;
      deg_known[v] = 1'b1;
      vtx_gone[v] = 1'b1;
      if (hi > MAX_NEIGHBOR_SLOTS) hi = MAX_NEIGHBOR_SLOTS;
      for (s = lo; s < hi; s++) begin
        u = adj_vertex[s];
        if (u != v && u < MAX_VERTICES && !vtx_gone[u] && vtx_degree[u] != 0) begin
          vtx_degree[u] = vtx_degree[u] - 1'b1;
          if (cut != CNT_MAX) cut = cut + 1'b1;
        end
      end
      return cut;
    endfunction

    // True when v is already deleted or a delete of v touches only written entries and a short range.
    function bit can_strip(int v);
      int lo;
      int hi;
      int s;
      int u;
      if (vtx_gone[v]) return 1'b1;
      if (!row_known[v] || !row_known[v+1]) return 1'b0;
      lo = row_first[v];
      hi = row_first[v+1];
      if (hi > MAX_NEIGHBOR_SLOTS) hi = MAX_NEIGHBOR_SLOTS;
      if (hi - lo > int'(WALK_MAX)) return 1'b0;
      for (s = lo; s < hi; s++) begin
        if (!adj_known[s]) return 1'b0;
        u = adj_vertex[s];
        if (u != v && u < MAX_VERTICES && !deg_known[u]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                            logic [VAL_W-1:0] val);
      result_t want;
      want = '0;
      items_noted++;
      case (mode)
        MODE_ROW_START: begin
          if (addr < RS_DEPTH) begin
            row_first[addr] = val;
            row_known[addr] = 1'b1;
          end else begin
            want.bad_address = 1'b1;
          end
        end
        MODE_NEIGHBOR: begin
          if (addr < MAX_NEIGHBOR_SLOTS) begin
            adj_vertex[addr] = val;
            adj_known[addr] = 1'b1;
          end else begin
            want.bad_address = 1'b1;
          end
        end
        MODE_DEGREE, MODE_DELETE, MODE_QUERY: begin
          if (addr >= MAX_VERTICES) begin
            want.bad_address = 1'b1;
          end else begin
            if (mode == MODE_DEGREE) begin
              vtx_degree[addr] = (val > DEG_MAX) ? DEG_MAX : val[DEG_W-1:0];
              deg_known[addr] = 1'b1;
            end else if (mode == MODE_DELETE && !vtx_gone[addr]) begin
              want.neighbors_updated = strip_vertex(addr);
            end
            want.degree = vtx_degree[addr];
            want.is_deleted = vtx_gone[addr];
          end
        end
        default: ;
      endcase
      owed_results = {owed_results, want};
    endfunction

    function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        fault_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, degree %0d deleted %0d updated %0d bad %0d",
                 $time, got.degree, got.is_deleted, got.neighbors_updated, got.bad_address);
        fault_count++;
        return;
      end
      want = owed_results.pop_front();
      check_field("degree", want.degree, got.degree);
      check_field("is_deleted", want.is_deleted, got.is_deleted);
      check_field("neighbors_updated", want.neighbors_updated, got.neighbors_updated);
      check_field("bad_address", want.bad_address, got.bad_address);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // -------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [MODE_W-1:0] in_mode_i = '0;
  logic [ADDR_W-1:0] in_address_i = '0;
  logic [VAL_W-1:0]  in_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DEG_W-1:0]  out_degree_o;
  logic              out_is_deleted_o;
  logic [CNT_W-1:0]  out_neighbors_updated_o;
  logic              out_bad_address_o;
  result_t           seen_result;

  degree_book book = new();

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  core_peel_degree_update dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .in_mode_i               (in_mode_i),
    .in_address_i            (in_address_i),
    .in_value_i              (in_value_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_degree_o            (out_degree_o),
    .out_is_deleted_o        (out_is_deleted_o),
    .out_neighbors_updated_o (out_neighbors_updated_o),
    .out_bad_address_o       (out_bad_address_o)
  );

  assign seen_result = {out_degree_o, out_is_deleted_o, out_neighbors_updated_o,
                        out_bad_address_o};

  // -------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts valid
  // drops for a random number of cycles. Every call starts and ends at a
  // falling edge, so each input changes at most once per time step, and valid
  // stays high from one item to the next inside a burst.
  // -------------------------------------------------------------------------
  task automatic send_item(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                           logic [VAL_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      // Now and then a long burst gives a stretch with no gaps at all.
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    in_mode_i    <= mode;
    in_address_i <= addr;
    in_value_i   <= val;
    // The item is taken at the first rising edge where the block does not stall.
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    book.note_item(mode, addr, val);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hand-picked items: field extremes, every defined mode, two spare modes and each corner of the peel.
  task automatic run_directed();
    // Vertex 0 owns slots 0..3, vertex 1 an empty range, vertex 2 a reversed one.
    send_item(MODE_ROW_START, 0, 0);
    send_item(MODE_ROW_START, 1, 4);
    send_item(MODE_ROW_START, 2, 4);
    send_item(MODE_ROW_START, 3, 2);
    send_item(MODE_NEIGHBOR, 0, 1);
    // A self loop, and a neighbour number far beyond the vertex range.
    send_item(MODE_NEIGHBOR, 1, 0);
    send_item(MODE_NEIGHBOR, 2, FIELD_MAX);
    send_item(MODE_NEIGHBOR, 3, 2);
    send_item(MODE_DEGREE, 0, 5);
    // Vertex 1 already sits at zero, so peeling vertex 0 must not count it.
    send_item(MODE_DEGREE, 1, 0);
    // An oversized degree is clipped to the largest 12-bit value.
    send_item(MODE_DEGREE, 2, FIELD_MAX);
    send_item(MODE_DELETE, 0, 0);
    send_item(MODE_QUERY, 2, 0);
    // A second delete of the same vertex must be ignored.
    send_item(MODE_DELETE, 0, FIELD_MAX);
    send_item(MODE_DELETE, 1, 0);
    send_item(MODE_DELETE, 2, 0);
    // The last vertex has a range that runs past the end of the neighbour list;
    // its first neighbour is already deleted.
    send_item(MODE_ROW_START, MAX_VERTICES - 1, MAX_NEIGHBOR_SLOTS - 2);
    send_item(MODE_ROW_START, MAX_VERTICES, FIELD_MAX);
    send_item(MODE_NEIGHBOR, MAX_NEIGHBOR_SLOTS - 2, 0);
    send_item(MODE_NEIGHBOR, MAX_NEIGHBOR_SLOTS - 1, MAX_VERTICES - 2);
    send_item(MODE_DEGREE, MAX_VERTICES - 2, DEG_MAX);
    send_item(MODE_DELETE, MAX_VERTICES - 1, 0);
    send_item(MODE_QUERY, MAX_VERTICES - 2, 0);
    // Addresses just past the range of the load and degree modes, a far delete, then two spare modes.
    send_item(MODE_ROW_START, RS_DEPTH, FIELD_MAX);
    send_item(MODE_NEIGHBOR, MAX_NEIGHBOR_SLOTS, FIELD_MAX);
    send_item(MODE_DEGREE, MAX_VERTICES, 1);
    send_item(MODE_DELETE, FIELD_MAX, 0);
    send_item(MODE_SPARE_LO, FIELD_MAX, FIELD_MAX);
    send_item(MODE_SPARE_HI, 0, 0);
  endtask

  // A well-formed fragment: row starts for a small window of vertices, their
  // neighbour slots and degrees, then a few deletes and queries inside it.
  // Windows often land near vertex 0, so repeated deletes and neighbours that
  // are already gone come up regularly.
  task automatic build_and_peel();
    int k;
    int v0;
    int s0;
    int total;
    int i;
    int u;
    int v;
    int ops;
    int pick;
    int starts [9];
    bit past_end;
    k = $urandom_range(1, 8);
    v0 = ($urandom_range(0, 99) < 40) ? $urandom_range(0, 40) : $urandom_range(0, MAX_VERTICES - k);
    past_end = ($urandom_range(0, 19) == 0);
    starts[0] = 0;
    total = 0;
    for (i = 0; i < k; i++) begin
      // Mostly growing offsets; sometimes one steps back to give a reversed range.
      if (starts[i] > 0 && $urandom_range(0, 9) == 0) starts[i+1] = starts[i] - 1;
      else starts[i+1] = starts[i] + $urandom_range(0, 6);
      if (starts[i+1] > total) total = starts[i+1];
    end
    s0 = past_end ? MAX_NEIGHBOR_SLOTS - total : $urandom_range(0, MAX_NEIGHBOR_SLOTS - total);
    for (i = 0; i <= k; i++) begin
      if (past_end && i == k) send_item(MODE_ROW_START, v0 + i, $urandom_range(MAX_NEIGHBOR_SLOTS, FIELD_MAX));
      else send_item(MODE_ROW_START, v0 + i, s0 + starts[i]);
    end
    for (i = s0; i < s0 + total; i++) begin
      pick = $urandom_range(0, 99);
      u = v0 + $urandom_range(0, k - 1);
      if (pick >= 90) begin
        u = $urandom_range(MAX_VERTICES, FIELD_MAX);
      end else if (pick >= 60) begin
        // Some vertex anywhere in the vertex range, provided its degree is defined.
        pick = $urandom_range(0, MAX_VERTICES - 1);
        if (book.deg_known[pick]) u = pick;
      end
      send_item(MODE_NEIGHBOR, i, u);
    end
    for (i = 0; i < k; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) u = 0;
      else if (pick < 20) u = $urandom_range(0, FIELD_MAX);
      else if (pick < 25) u = DEG_MAX;
      else u = $urandom_range(1, 6);
      send_item(MODE_DEGREE, v0 + i, u);
    end
    ops = $urandom_range(1, k + 2);
    for (i = 0; i < ops; i++) begin
      v = v0 + $urandom_range(0, k - 1);
      if ($urandom_range(0, 99) < 60 && book.can_strip(v))
        send_item(MODE_DELETE, v, $urandom_range(0, FIELD_MAX));
      else
        send_item(MODE_QUERY, v, $urandom_range(0, FIELD_MAX));
    end
  endtask

  // Loose items: any mode, addresses in range, just past it or anywhere in
  // the 13-bit field. Deletes and queries that would read undefined entries
  // are turned into harmless alternatives.
  task automatic send_noise();
    int n;
    int i;
    int lim;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    n = $urandom_range(1, 12);
    for (i = 0; i < n; i++) begin
      mode = $urandom_range(0, 7);
      if (mode == MODE_ROW_START) lim = RS_DEPTH;
      else if (mode == MODE_NEIGHBOR) lim = MAX_NEIGHBOR_SLOTS;
      else lim = MAX_VERTICES;
      case ($urandom_range(0, 9))
        0, 1, 2: addr = $urandom_range(0, FIELD_MAX);
        3:       addr = lim;
        default: addr = $urandom_range(0, lim - 1);
      endcase
      if (addr < MAX_VERTICES) begin
        if (mode == MODE_DELETE && !book.can_strip(addr)) mode = MODE_QUERY;
        if (mode == MODE_QUERY && !book.deg_known[addr]) mode = MODE_DEGREE;
      end
      send_item(mode, addr, $urandom_range(0, FIELD_MAX));
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver. The stall changes at falling edges and follows a style that is
  // redrawn when its random run ends. Once, after a few hundred items, it
  // holds off for a long stretch so that the block backs up and stalls its
  // input while the sender keeps offering items.
  // -------------------------------------------------------------------------
  initial begin : receiver
    stall_style_e style;
    int unsigned  style_left;
    int unsigned  hold_left;
    int unsigned  tick;
    bit           held_once;
    style = STALL_NONE;
    style_left = 0;
    hold_left = 0;
    tick = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (!held_once && book.items_noted >= 400) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (style_left == 0) begin
          style = stall_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(40, 300);
        end
        style_left--;
        case (style)
          STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 25);
          STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 99) < 70);
          STALL_PERIODIC: out_stall_i <= ((tick % 7) < 3);
          default:        out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Results are taken at rising edges where valid is high and we do not stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) book.check_result(seen_result);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, book.owed_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence. Reset is held low at the start; the block then clears its
  // deleted flags on its own and stalls its input meanwhile, which the
  // handshake in send_item simply waits out.
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_goal;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      if ($urandom_range(0, 99) < 50) build_and_peel();
      else send_noise();
    end
    in_valid_i <= 1'b0;
    // Wait for every owed result, then a little longer to catch stray ones.
    while (book.owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.owed_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, book.owed_results.size());
      book.fault_count++;
    end
    if (book.fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
